### rtl/sqfc_pkg.sv
// Package for the squarefree counter: shared command and status types.
// Used by sqfc_ctrl, sqfc_dp and squarefree_count_mobius_unit.
package sqfc_pkg;

  localparam int unsigned BoundW = 33;

  // Controller commands to the datapath
  typedef struct packed {
    logic init_start;   // start the table build
    logic query_start;  // latch bound (from idle) and run the sum
  } sqfc_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic init_done;
    logic query_done;
  } sqfc_sts_t;

endpackage

### rtl/sqfc_ctrl.sv
// Controller for the squarefree counter: sequences table build and queries.
// Depends on sqfc_pkg.
module sqfc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  output sqfc_pkg::sqfc_cmd_t cmd_o,
  input  sqfc_pkg::sqfc_sts_t sts_i
);
  import sqfc_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StBuild = 2'd1;
  localparam logic [1:0] StSum   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       built_q, built_d;
  logic       done_q, done_d;

  // next-state logic
  always_comb begin
    state_d = state_q;
    built_d = built_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.query_start = built_q;
          cmd_o.init_start  = !built_q;
          state_d = built_q ? StSum : StBuild;
        end
      end
      StBuild: begin
        if (sts_i.init_done) begin
          built_d = 1'b1;
          cmd_o.query_start = 1'b1;
          state_d = StSum;
        end
      end
      StSum: begin
        if (sts_i.query_done) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      built_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == StIdle) else $error("done outside idle");
  a_sum_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSum |-> built_q) else $error("sum before build");
  a_built_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(built_q) |-> built_q) else $error("built flag cleared");
endmodule

### rtl/sqfc_dp.sv
// Datapath for the squarefree counter: sieve memories, Mobius build,
// and the sum with a bit-serial divider. Depends on sqfc_pkg.
module sqfc_dp #(
  parameter int unsigned SieveW = 16,
  parameter int unsigned PrimeW = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqfc_pkg::sqfc_cmd_t cmd_i,
  output sqfc_pkg::sqfc_sts_t sts_o,
  input  logic [32:0]         bound_i,
  output logic [32:0]         count_o
);
  import sqfc_pkg::*;

  localparam int unsigned Depth = 1 << SieveW;
  localparam int unsigned Slots = 1 << PrimeW;
  localparam int unsigned CapW  = 2 * SieveW + 1;
  localparam int unsigned DivW  = (CapW > BoundW) ? CapW : BoundW;
  localparam int unsigned CntW  = $clog2(DivW + 1);
  localparam logic [DivW-1:0] Cap = DivW'(1) << (2 * SieveW);

  // Phases of the datapath sequencer
  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhClear  = 4'd1;
  localparam logic [3:0] PhLpfRd  = 4'd2;
  localparam logic [3:0] PhLpfChk = 4'd3;
  localparam logic [3:0] PhInRd   = 4'd4;
  localparam logic [3:0] PhInChk  = 4'd5;
  localparam logic [3:0] PhFlpRd  = 4'd6;
  localparam logic [3:0] PhFlpWr  = 4'd7;
  localparam logic [3:0] PhSqWr   = 4'd8;
  localparam logic [3:0] PhSumRd  = 4'd9;
  localparam logic [3:0] PhSumChk = 4'd10;
  localparam logic [3:0] PhDiv    = 4'd11;
  localparam logic [3:0] PhOut    = 4'd12;

  // memories: mobius as 2-bit code (00 zero, 01 plus, 11 minus)
  logic [1:0]        mob_mem [Depth];
  logic [SieveW-1:0] lpf_mem [Depth];
  logic [SieveW-1:0] prm_mem [Slots];
  logic [1:0]        mob_rd_q;
  logic [SieveW-1:0] lpf_rd_q, prm_rd_q;

  logic [3:0]          ph_q;
  logic [SieveW:0]     i_q;        // sieve index / sum index
  logic [PrimeW:0]     n_q;        // prime loop index
  logic [PrimeW:0]     total_q;    // prime count
  logic [SieveW-1:0]   lpf_i_q;    // lpf of current i
  logic [SieveW:0]     p_q;        // current prime
  logic [2*SieveW+1:0] j_q;        // multiple walker
  logic [DivW-1:0]     bound_q;
  logic [DivW-1:0]     sq_q;       // k*k
  logic [DivW-1:0]     rem_q, quo_q;
  logic [CntW-1:0]     bit_q;
  logic [DivW+1:0]     sum_q;      // signed running sum
  logic                neg_q;
  logic                fin_q;      // PhOut reached from the end of the sum

  // memory ports driven by the sequencer
  logic              mob_we, lpf_we, prm_we;
  logic [SieveW-1:0] mob_wa, lpf_wa, mob_ra, lpf_ra;
  logic [PrimeW-1:0] prm_wa, prm_ra;
  logic [1:0]        mob_wd;
  logic [SieveW-1:0] lpf_wd, prm_wd;

  always_ff @(posedge clk_i) begin
    if (mob_we) mob_mem[mob_wa] <= mob_wd;
    mob_rd_q <= mob_mem[mob_ra];
  end
  always_ff @(posedge clk_i) begin
    if (lpf_we) lpf_mem[lpf_wa] <= lpf_wd;
    lpf_rd_q <= lpf_mem[lpf_ra];
  end
  always_ff @(posedge clk_i) begin
    if (prm_we) prm_mem[prm_wa] <= prm_wd;
    prm_rd_q <= prm_mem[prm_ra];
  end

  logic [2*SieveW+1:0] ip_prod;
  logic [DivW:0]       rem_sh;
  assign ip_prod = (2*SieveW+2)'(i_q) * (2*SieveW+2)'(prm_rd_q);
  assign rem_sh  = {rem_q, quo_q[DivW-1]};

  // memory port control
  always_comb begin
    mob_we = 1'b0; lpf_we = 1'b0; prm_we = 1'b0;
    mob_wa = j_q[SieveW-1:0]; mob_wd = 2'b01;
    lpf_wa = i_q[SieveW-1:0]; lpf_wd = '0;
    prm_wa = total_q[PrimeW-1:0]; prm_wd = i_q[SieveW-1:0];
    mob_ra = j_q[SieveW-1:0]; lpf_ra = i_q[SieveW-1:0];
    prm_ra = n_q[PrimeW-1:0];
    case (ph_q)
      PhClear: begin
        lpf_we = 1'b1;
        mob_we = 1'b1; mob_wa = i_q[SieveW-1:0];
        mob_wd = (i_q == '0) ? 2'b00 : 2'b01;
      end
      PhLpfChk: begin
        if (lpf_rd_q == '0) begin
          lpf_we = 1'b1; lpf_wd = i_q[SieveW-1:0];
          prm_we = (total_q < (PrimeW+1)'(Slots));
        end
      end
      PhInChk: begin
        lpf_wa = ip_prod[SieveW-1:0]; lpf_wd = prm_rd_q;
        lpf_we = (n_q < total_q) && ((SieveW+1)'(prm_rd_q) <= (SieveW+1)'(lpf_i_q))
                 && (ip_prod < (2*SieveW+2)'(Depth));
      end
      PhFlpWr: begin
        mob_we = 1'b1;
        mob_wd = (mob_rd_q == 2'b00) ? 2'b00 : ~mob_rd_q + 2'b01;
      end
      PhSqWr: begin
        mob_we = (j_q < (2*SieveW+2)'(Depth)); mob_wd = 2'b00;
      end
      PhSumRd: mob_ra = i_q[SieveW-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PhIdle;
      total_q <= '0;
      sum_q   <= '0;
      i_q <= '0; n_q <= '0; p_q <= '0; j_q <= '0; bit_q <= '0;
      bound_q <= '0; sq_q <= '0; rem_q <= '0; quo_q <= '0;
      neg_q <= 1'b0; lpf_i_q <= '0;
    end else begin
      case (ph_q)
        PhIdle: begin
          if (cmd_i.init_start) begin
            bound_q <= (DivW'(bound_i) > Cap) ? Cap : DivW'(bound_i);
            ph_q <= PhClear; i_q <= '0; total_q <= '0;
          end else if (cmd_i.query_start) begin
            bound_q <= (DivW'(bound_i) > Cap) ? Cap : DivW'(bound_i);
            sum_q <= '0; i_q <= (SieveW+1)'(1); ph_q <= PhSumRd;
          end
        end
        PhClear: begin
          if (i_q == (SieveW+1)'(Depth - 1)) begin
            i_q <= (SieveW+1)'(2); ph_q <= PhLpfRd;
          end else i_q <= i_q + 1'b1;
        end
        PhLpfRd: ph_q <= PhLpfChk;
        PhLpfChk: begin
          lpf_i_q <= (lpf_rd_q == '0) ? i_q[SieveW-1:0] : lpf_rd_q;
          if (lpf_rd_q == '0 && total_q < (PrimeW+1)'(Slots)) total_q <= total_q + 1'b1;
          n_q <= '0; ph_q <= PhInRd;
        end
        PhInRd: ph_q <= PhInChk;
        PhInChk: begin
          p_q <= (SieveW+1)'(prm_rd_q);
          if (lpf_we) begin
            n_q <= n_q + 1'b1; ph_q <= PhInRd;
          end else if (i_q == (SieveW+1)'(Depth - 1)) begin
            n_q <= '0; ph_q <= PhFlpRd; p_q <= '0;
          end else begin
            i_q <= i_q + 1'b1; ph_q <= PhLpfRd;
          end
        end
        // flip phase: p_q==0 means fetch next prime; the held query follows the build
        PhFlpRd: begin
          if (p_q == '0) begin
            if (n_q == total_q) begin
              if (cmd_i.query_start) begin
                sum_q <= '0; i_q <= (SieveW+1)'(1); ph_q <= PhSumRd;
              end else ph_q <= PhIdle;
            end else if (bit_q == '0) bit_q <= CntW'(1);
            else begin
              bit_q <= '0;
              p_q <= (SieveW+1)'(prm_rd_q);
              j_q <= (2*SieveW+2)'(prm_rd_q);
              n_q <= n_q + 1'b1;
            end
          end else if (j_q >= (2*SieveW+2)'(Depth)) begin
            j_q <= (2*SieveW+2)'(p_q) * (2*SieveW+2)'(p_q);
            ph_q <= PhSqWr;
          end else ph_q <= PhFlpWr;
        end
        PhFlpWr: begin
          j_q <= j_q + (2*SieveW+2)'(p_q); ph_q <= PhFlpRd;
        end
        PhSqWr: begin
          if (j_q >= (2*SieveW+2)'(Depth)) begin
            p_q <= '0; ph_q <= PhFlpRd;
          end else j_q <= j_q + (2*SieveW+2)'(p_q) * (2*SieveW+2)'(p_q);
        end
        PhSumRd: begin
          sq_q <= DivW'(i_q) * DivW'(i_q);
          ph_q <= PhSumChk;
        end
        PhSumChk: begin
          if (i_q == (SieveW+1)'(Depth) || sq_q > bound_q) ph_q <= PhOut;
          else if (mob_rd_q == 2'b00) begin
            i_q <= i_q + 1'b1; ph_q <= PhSumRd;
          end else begin
            neg_q <= mob_rd_q[1]; rem_q <= '0; quo_q <= bound_q;
            bit_q <= CntW'(DivW); ph_q <= PhDiv;
          end
        end
        // restoring divider, one quotient bit per cycle
        PhDiv: begin
          if (rem_sh >= {1'b0, sq_q}) rem_q <= DivW'(rem_sh - {1'b0, sq_q});
          else rem_q <= rem_sh[DivW-1:0];
          quo_q <= {quo_q[DivW-2:0], rem_sh >= {1'b0, sq_q}};
          bit_q <= bit_q - 1'b1;
          if (bit_q == CntW'(1)) begin
            ph_q <= PhOut; i_q <= i_q + 1'b1;
          end
        end
        PhOut: begin
          if (fin_q) ph_q <= PhIdle;
          else begin
            sum_q <= neg_q ? sum_q - (DivW+2)'(quo_q) : sum_q + (DivW+2)'(quo_q);
            ph_q <= PhSumRd;
          end
        end
        default: ph_q <= PhIdle;
      endcase
    end
  end

  // PhOut is entered either to finish (from PhSumChk) or to accumulate a
  // quotient (from PhDiv); fin_q tells the two apart.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_q <= 1'b0;
    else fin_q <= (ph_q == PhSumChk) && (i_q == (SieveW+1)'(Depth) || sq_q > bound_q);
  end

  assign sts_o.init_done  = (ph_q == PhFlpRd) && (p_q == '0) && (n_q == total_q);
  assign sts_o.query_done = (ph_q == PhOut) && fin_q;
  assign count_o = sum_q[DivW+1] ? '0 : sum_q[32:0];

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PhDiv |-> bit_q != '0) else $error("divider count underflow");
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= (PrimeW+1)'(Slots)) else $error("prime count overflow");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.query_done |=> !sts_o.query_done) else $error("repeated done");
endmodule

### rtl/squarefree_count_mobius_unit.sv
// Top level of the squarefree counter: controller plus datapath.
// Depends on sqfc_pkg, sqfc_ctrl and sqfc_dp.
//
// Usage: drive upper_bound_i and raise start while busy is low; the word
// is taken at that edge. The answer appears on squarefree_count_o for one
// cycle with done_o high; the receiver cannot stall it.
// The first query after reset first builds the Mobius table: a clearing
// sweep over all 2**SIEVE_BITS entries, a linear sieve that visits each
// index and its inner steps, and a sign-flip pass over the multiples of
// each prime and then over the multiples of its square.
// Each query then walks k = 1.. while k*k <= bound and k < 2**SIEVE_BITS,
// running a one-bit-per-cycle restoring divider and an accumulate
// for each k with non-zero Mobius value.
// The single divider and the single read port of the table set the query time.
// Reset drops the table; the next query rebuilds it.
module squarefree_count_mobius_unit #(
  parameter int unsigned SIEVE_BITS = 16,
  parameter int unsigned PRIME_BITS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [32:0] upper_bound_i,
  output logic [32:0] squarefree_count_o
);
  import sqfc_pkg::*;

  sqfc_cmd_t cmd;
  sqfc_sts_t sts;

  sqfc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .done_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  sqfc_dp #(.SieveW(SIEVE_BITS), .PrimeW(PRIME_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .bound_i(upper_bound_i), .count_o(squarefree_count_o)
  );
endmodule
